// ===== rtl/oreg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oreg_pkg
// Shared types and constants of the instance ownership registry: request
// codes, field widths, the request bundle, the scan token that moves along
// the slot chain and the commit command that the controller sends to it.
// ----------------------------------------------------------------------------
package oreg_pkg;

    // Field widths.
    localparam int KIND_W  = 2;
    localparam int WORD_W  = 64;
    localparam int CFG_W   = 9;

    // Request kinds.
    localparam logic [KIND_W-1:0] REQ_CLAIM   = 2'd0;
    localparam logic [KIND_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_QUERY   = 2'd2;

    // Request held by the controller while the scan runs.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] id_high;
        logic [WORD_W-1:0] id_low;
        logic [WORD_W-1:0] owner;
    } t_req;

    // Scan token handed from one slot cell to the next.
    typedef struct packed {
        logic valid;       // token present at this point of the chain
        logic hit;         // an occupied slot with the id has been seen
        logic own_ok;      // that first matching slot has the request's owner
        logic free_found;  // an empty slot was seen before any hit
    } t_tok;

    // Commit command, one cycle wide, broadcast to all cells.
    typedef struct packed {
        logic set;  // the marked empty slot takes the request's id and owner
        logic clr;  // the marked matching slot is emptied
    } t_cmd;

endpackage

// ===== rtl/oreg_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oreg_req_if
// Request channel: valid/ready handshake with kind, instance id and owner.
// ----------------------------------------------------------------------------
interface oreg_req_if;
    import oreg_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] req_type;
    logic [WORD_W-1:0] id_high;
    logic [WORD_W-1:0] id_low;
    logic [WORD_W-1:0] owner_tag;

    modport source (output valid, output req_type, output id_high, output id_low,
                    output owner_tag, input ready);
    modport sink   (input valid, input req_type, input id_high, input id_low,
                    input owner_tag, output ready);
endinterface

// ===== rtl/oreg_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oreg_rsp_if
// Response channel: valid/ready handshake with the one-bit success flag.
// ----------------------------------------------------------------------------
interface oreg_rsp_if;
    logic valid;
    logic ready;
    logic success;

    modport source (output valid, output success, input ready);
    modport sink   (input valid, input success, output ready);
endinterface

// ===== rtl/oreg_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oreg_cfg_if
// Configuration write channel: valid/ready handshake with the capacity value.
// ----------------------------------------------------------------------------
interface oreg_cfg_if;
    import oreg_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/oreg_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oreg_cell
// One table slot. It holds an id and an owner, inspects the scan token as it
// passes, marks itself as the claim target or the first id match, and hands
// the updated token to the next cell through its token register.
// ----------------------------------------------------------------------------
module oreg_cell #(
    parameter int CELL_IDX = 0,
    parameter int CAP_W    = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  oreg_pkg::t_req     i_req,
    input  logic [CAP_W-1:0]   i_capacity,
    input  oreg_pkg::t_tok     i_tok,
    input  oreg_pkg::t_cmd     i_cmd,
    output oreg_pkg::t_tok     o_tok
);
    import oreg_pkg::*;

    logic [WORD_W-1:0] r_id_high;
    logic [WORD_W-1:0] r_id_low;
    logic [WORD_W-1:0] r_owner;
    logic              r_occ;
    logic              r_mark_free;
    logic              r_mark_hit;
    t_tok              r_tok;

    logic              n_mark_free;
    logic              n_mark_hit;
    t_tok              n_tok;
    logic              active;
    logic              id_match;

    assign active   = CAP_W'(CELL_IDX) < i_capacity;
    assign id_match = (r_id_high == i_req.id_high) && (r_id_low == i_req.id_low);

    // Token update and target marking as the scan passes this slot.
    always_comb begin
        n_tok       = i_tok;
        n_mark_free = r_mark_free;
        n_mark_hit  = r_mark_hit;
        if (i_tok.valid) begin
            n_mark_free = 1'b0;
            n_mark_hit  = 1'b0;
            if (active) begin
                if (!r_occ) begin
                    if (!i_tok.free_found && !i_tok.hit) begin
                        n_mark_free      = 1'b1;
                        n_tok.free_found = 1'b1;
                    end
                end else if (id_match && !i_tok.hit) begin
                    n_mark_hit   = 1'b1;
                    n_tok.hit    = 1'b1;
                    n_tok.own_ok = (r_owner == i_req.owner);
                end
            end
        end
    end

    // Control state: token, marks and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok       <= '0;
            r_mark_free <= 1'b0;
            r_mark_hit  <= 1'b0;
            r_occ       <= 1'b0;
        end else begin
            r_tok       <= n_tok;
            r_mark_free <= n_mark_free;
            r_mark_hit  <= n_mark_hit;
            if (i_cmd.set && r_mark_free) begin
                r_occ <= 1'b1;
            end else if (i_cmd.clr && r_mark_hit) begin
                r_occ <= 1'b0;
            end
        end
    end

    // Slot contents, written on a committed claim.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set && r_mark_free) begin
            r_id_high <= i_req.id_high;
            r_id_low  <= i_req.id_low;
            r_owner   <= i_req.owner;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/oreg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oreg_ctrl
// Request sequencer: takes one request, launches the scan token into the
// slot chain, decides the outcome when the token leaves the chain, sends the
// commit command, and keeps the capacity register and the occupancy count.
// ----------------------------------------------------------------------------
module oreg_ctrl #(
    parameter int TABLE_SLOTS = 256,
    parameter int CAP_W       = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    oreg_req_if.sink           i_req,
    oreg_rsp_if.source         o_rsp,
    oreg_cfg_if.sink           i_cfg,
    input  oreg_pkg::t_tok     i_tok_end,
    output oreg_pkg::t_tok     o_tok_start,
    output oreg_pkg::t_req     o_req,
    output logic [CAP_W-1:0]   o_capacity,
    output oreg_pkg::t_cmd     o_cmd
);
    import oreg_pkg::*;

    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    t_state             r_state;
    t_req               r_req;
    logic               r_inject;
    logic [CAP_W-1:0]   r_capacity;
    logic [CNT_W-1:0]   r_count;
    logic               r_out_valid;
    logic               r_out_success;
    logic               r_pend;

    logic               n_out_valid;
    logic               req_ok;
    logic               claim_ok;
    logic               rel_ok;
    logic               qry_ok;
    logic               success;
    logic               done;
    logic               out_free;
    logic [CAP_W-1:0]   cfg_value;
    logic               cfg_ok;

    assign i_req.ready = i_rst_n && (r_state == ST_IDLE);
    assign i_cfg.ready = i_rst_n;

    // Outcome of the scan when the token leaves the last cell.
    assign done     = (r_state == ST_SCAN) && i_tok_end.valid;
    assign req_ok   = ((r_req.id_high != '0) || (r_req.id_low != '0)) && (r_req.owner != '0);
    assign claim_ok = req_ok && (r_req.kind == REQ_CLAIM) && !i_tok_end.hit
                      && i_tok_end.free_found;
    assign rel_ok   = req_ok && (r_req.kind == REQ_RELEASE) && i_tok_end.hit
                      && i_tok_end.own_ok;
    assign qry_ok   = req_ok && (r_req.kind == REQ_QUERY) && i_tok_end.hit
                      && i_tok_end.own_ok;
    assign success  = claim_ok || rel_ok || qry_ok;

    // Commit command to the marked cell.
    always_comb begin
        o_cmd.set = done && claim_ok;
        o_cmd.clr = done && rel_ok;
    end

    // Scan token launch.
    always_comb begin
        o_tok_start       = '0;
        o_tok_start.valid = r_inject;
    end

    assign out_free = !r_out_valid || o_rsp.ready;

    // Response valid: cleared when taken, set when a result is loaded.
    always_comb begin
        n_out_valid = r_out_valid && !o_rsp.ready;
        if ((done || (r_state == ST_HOLD)) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // A capacity write is taken only when in range and the table is empty.
    assign cfg_value = CAP_W'(i_cfg.data);
    assign cfg_ok    = (cfg_value != '0) && (cfg_value <= CAP_W'(TABLE_SLOTS))
                       && (r_count == '0);

    // State, occupancy count, capacity and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inject    <= 1'b0;
            r_capacity  <= CAP_W'(TABLE_SLOTS);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_inject    <= (r_state == ST_IDLE) && i_req.valid;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && cfg_ok) begin
                r_capacity <= cfg_value;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (i_tok_end.valid) begin
                        if (claim_ok) begin
                            r_count <= r_count + CNT_W'(1);
                        end else if (rel_ok) begin
                            r_count <= r_count - CNT_W'(1);
                        end
                        if (out_free) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.kind    <= i_req.req_type;
            r_req.id_high <= i_req.id_high;
            r_req.id_low  <= i_req.id_low;
            r_req.owner   <= i_req.owner_tag;
        end
        if (done) begin
            r_pend <= success;
            if (out_free) begin
                r_out_success <= success;
            end
        end else if ((r_state == ST_HOLD) && out_free) begin
            r_out_success <= r_pend;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.success = r_out_success;
    assign o_req         = r_req;
    assign o_capacity    = r_capacity;

endmodule

// ===== rtl/instance_ownership_registry_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instance_ownership_registry_unit
// Ownership table of TABLE_SLOTS slots that claims, releases and queries
// 128-bit instance ids for 64-bit owner tags.
// ----------------------------------------------------------------------------
// One request is handled at a time: after acceptance a launch register starts
// a scan token that walks the chain of slot cells one cell per cycle, and when
// the token leaves the chain the outcome is committed and the response
// register is loaded. The response register is separate, but a finished
// result that is not taken holds off the next request. The table is empty
// after reset with no clearing pass. A capacity write is taken only when its
// value is in 1..TABLE_SLOTS and no slot is occupied; any other write is
// dropped.
// ----------------------------------------------------------------------------
module instance_ownership_registry_unit #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oreg_req_if.sink    i_req,
    oreg_rsp_if.source  o_rsp,
    oreg_cfg_if.sink    i_cfg
);
    import oreg_pkg::*;

    localparam int CAP_W = ($clog2(TABLE_SLOTS + 1) > CFG_W) ?
                           $clog2(TABLE_SLOTS + 1) : CFG_W;

    t_tok             tok [TABLE_SLOTS+1];
    t_req             req;
    t_cmd             cmd;
    logic [CAP_W-1:0] capacity;

    // Request sequencer.
    oreg_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .CAP_W       (CAP_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cfg       (i_cfg),
        .i_tok_end   (tok[TABLE_SLOTS]),
        .o_tok_start (tok[0]),
        .o_req       (req),
        .o_capacity  (capacity),
        .o_cmd       (cmd)
    );

    // Chain of slot cells; the token moves one cell per cycle.
    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        oreg_cell #(
            .CELL_IDX (g),
            .CAP_W    (CAP_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_req      (req),
            .i_capacity (capacity),
            .i_tok      (tok[g]),
            .i_cmd      (cmd),
            .o_tok      (tok[g+1])
        );
    end

endmodule
